// ----- design/rational_arith_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rational arithmetic unit
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RAU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RAU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// Widths, opcodes and controller/datapath interface types of the unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_BITS = 16;
    localparam int OPCODE_W     = 3;
    localparam int PROD_W       = 2 * OPERAND_BITS;
    localparam int SUM_W        = PROD_W + 1;
    localparam int MAG_W        = PROD_W;
    localparam int SHIFT_W      = $clog2(MAG_W);
    localparam int DCNT_W       = $clog2(MAG_W + 1);
    localparam int RES_NUM_W    = 33;
    localparam int RES_DEN_W    = 31;
    localparam int S_TDATA_W    = ((OPCODE_W + 4 * OPERAND_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((RES_NUM_W + RES_DEN_W + 1 + 7) / 8) * 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4,
        OP_GT  = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        MS_P0,
        MS_P1,
        MS_DEN
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     comb;
        logic     gcd_step;
        logic     div_init;
        logic     div_step;
        logic     res_load;
    } dp_cmd_t;

    typedef struct packed {
        logic early;
        logic gcd_done;
        logic div_done;
    } dp_stat_t;

endpackage

// ----- design/rau_datapath.sv -----
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, shared multiplier, combine stage, binary GCD and a pair
// of restoring dividers that reduce numerator and denominator together.
// ----------------------------------------------------------------------------
module rau_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [rau_pkg::S_TDATA_W-1:0]    in_data,
    input  rau_pkg::dp_cmd_t                 cmd,
    output rau_pkg::dp_stat_t                stat,
    output logic [rau_pkg::M_TDATA_W-1:0]    res_tdata,
    output logic                             res_undef
);
    import rau_pkg::*;

    logic [OPCODE_W-1:0]            op_reg;
    logic signed [OPERAND_BITS-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [OPERAND_BITS-1:0] mul_x, mul_y;
    logic signed [PROD_W-1:0]       mul_p;
    logic signed [PROD_W-1:0]       p0_reg, p1_reg, pd_reg;

    logic signed [SUM_W-1:0]        p0x, p1x, diff, sum_v, sum_abs;
    logic signed [PROD_W-1:0]       pd_abs;
    logic                           a_undef, b_undef;
    logic                           early, e_undef, e_truth, e_unit;
    logic                           early_reg, e_undef_reg, e_truth_reg, e_unit_reg;
    logic                           neg_reg;

    logic [MAG_W-1:0]               u_reg, v_reg, g_reg;
    logic [SHIFT_W-1:0]             k_reg;
    logic [MAG_W-1:0]               q_n_reg, q_d_reg, rem_n_reg, rem_d_reg;
    logic [MAG_W:0]                 trial_n, trial_d, g_ext;
    logic [DCNT_W-1:0]              cnt_reg;

    logic signed [MAG_W:0]          qn_s, qn_v;
    logic signed [RES_NUM_W-1:0]    res_num_reg;
    logic [RES_DEN_W-1:0]           res_den_reg;
    logic                           res_undef_reg, res_truth_reg;

    // operand pairs per product slot
    always_comb
    begin
        mul_x = an_reg;
        mul_y = bd_reg;
        unique case (cmd.mul_sel)
            MS_P0:
            begin
                mul_x = an_reg;
                mul_y = (op_reg == OP_MUL) ? bn_reg : bd_reg;
            end
            MS_P1:
            begin
                mul_x = bn_reg;
                mul_y = ad_reg;
            end
            MS_DEN:
            begin
                mul_x = ad_reg;
                mul_y = (op_reg == OP_DIV) ? bn_reg : bd_reg;
            end
            default:
            begin
                mul_x = an_reg;
                mul_y = bd_reg;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

    assign p0x     = SUM_W'(p0_reg);
    assign p1x     = SUM_W'(p1_reg);
    assign diff    = p0x - p1x;
    assign a_undef = (ad_reg == '0);
    assign b_undef = (bd_reg == '0);

    always_comb
    begin
        sum_v = p0x;
        if (op_reg == OP_ADD)
            sum_v = p0x + p1x;
        else if (op_reg == OP_SUB)
            sum_v = diff;
        early   = 1'b1;
        e_undef = 1'b0;
        e_truth = 1'b0;
        e_unit  = 1'b0;
        case (op_reg) inside
            OP_EQ:
                e_truth = (a_undef || b_undef) ? (a_undef && b_undef) : (diff == '0);
            OP_GT:
                e_truth = (a_undef || b_undef) ? (a_undef && !b_undef) :
                          ((diff != '0) &&
                           ((diff < 0) == (ad_reg[OPERAND_BITS-1] ^ bd_reg[OPERAND_BITS-1])));
            OP_ADD, OP_SUB, OP_MUL, OP_DIV:
            begin
                if (a_undef || b_undef || pd_reg == '0)
                    e_undef = 1'b1;
                else if (sum_v == '0)
                    e_unit = 1'b1;
                else
                    early = 1'b0;
            end
            default:
                early = 1'b1;
        endcase
    end

    assign sum_abs = sum_v[SUM_W-1] ? -sum_v : sum_v;
    assign pd_abs  = pd_reg[PROD_W-1] ? -pd_reg : pd_reg;

    assign g_ext   = {1'b0, g_reg};
    assign trial_n = {rem_n_reg, q_n_reg[MAG_W-1]};
    assign trial_d = {rem_d_reg, q_d_reg[MAG_W-1]};

    assign stat.early    = early;
    assign stat.gcd_done = (u_reg == '0) || (v_reg == '0);
    assign stat.div_done = (cnt_reg == DCNT_W'(MAG_W));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.div_init)
            cnt_reg <= '0;
        else if (cmd.div_step)
            cnt_reg <= cnt_reg + DCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_data[OPCODE_W-1:0];
            an_reg <= in_data[OPCODE_W +: OPERAND_BITS];
            ad_reg <= in_data[OPCODE_W + OPERAND_BITS +: OPERAND_BITS];
            bn_reg <= in_data[OPCODE_W + 2 * OPERAND_BITS +: OPERAND_BITS];
            bd_reg <= in_data[OPCODE_W + 3 * OPERAND_BITS +: OPERAND_BITS];
        end

        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                MS_P0:   p0_reg <= mul_p;
                MS_P1:   p1_reg <= mul_p;
                default: pd_reg <= mul_p;
            endcase
        end

        if (cmd.comb)
        begin
            early_reg   <= early;
            e_undef_reg <= e_undef;
            e_truth_reg <= e_truth;
            e_unit_reg  <= e_unit;
            neg_reg     <= sum_v[SUM_W-1] ^ pd_reg[PROD_W-1];
            u_reg       <= sum_abs[MAG_W-1:0];
            v_reg       <= pd_abs[MAG_W-1:0];
            q_n_reg     <= sum_abs[MAG_W-1:0];
            q_d_reg     <= pd_abs[MAG_W-1:0];
            k_reg       <= '0;
        end

        // binary GCD: strip common twos, halve an even operand, else subtract odd ones
        if (cmd.gcd_step)
        begin
            if (!u_reg[0] && !v_reg[0])
            begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + SHIFT_W'(1);
            end
            else if (!u_reg[0])
                u_reg <= u_reg >> 1;
            else if (!v_reg[0])
                v_reg <= v_reg >> 1;
            else if (u_reg >= v_reg)
                u_reg <= u_reg - v_reg;
            else
                v_reg <= v_reg - u_reg;
        end

        if (cmd.div_init)
        begin
            g_reg     <= (u_reg | v_reg) << k_reg;
            rem_n_reg <= '0;
            rem_d_reg <= '0;
        end

        if (cmd.div_step)
        begin
            if (trial_n >= g_ext)
            begin
                rem_n_reg <= MAG_W'(trial_n - g_ext);
                q_n_reg   <= {q_n_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_n_reg <= trial_n[MAG_W-1:0];
                q_n_reg   <= {q_n_reg[MAG_W-2:0], 1'b0};
            end
            if (trial_d >= g_ext)
            begin
                rem_d_reg <= MAG_W'(trial_d - g_ext);
                q_d_reg   <= {q_d_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_d_reg <= trial_d[MAG_W-1:0];
                q_d_reg   <= {q_d_reg[MAG_W-2:0], 1'b0};
            end
        end

        if (cmd.res_load)
        begin
            if (early_reg)
            begin
                res_num_reg   <= '0;
                res_den_reg   <= e_unit_reg ? RES_DEN_W'(1) : '0;
                res_undef_reg <= e_undef_reg;
                res_truth_reg <= e_truth_reg;
            end
            else
            begin
                res_num_reg   <= RES_NUM_W'(qn_v);
                res_den_reg   <= RES_DEN_W'(q_d_reg);
                res_undef_reg <= 1'b0;
                res_truth_reg <= 1'b0;
            end
        end
    end

    assign qn_s = {1'b0, q_n_reg};
    assign qn_v = neg_reg ? -qn_s : qn_s;

    assign res_tdata = M_TDATA_W'({res_truth_reg, res_den_reg, res_num_reg});
    assign res_undef = res_undef_reg;

endmodule

// ----- design/rau_ctrl.sv -----
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: multiply, combine, GCD and divide (both skipped for early results), then hand off to output register.
// ----------------------------------------------------------------------------
`include "rational_arith_unit_assert.svh"

module rau_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output rau_pkg::dp_cmd_t   cmd,
    input  rau_pkg::dp_stat_t  stat
);
    import rau_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P0,
        ST_MUL_P1,
        ST_MUL_DEN,
        ST_COMB,
        ST_GCD,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.mul_sel   = MS_P0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL_P0;
                end
            end
            ST_MUL_P0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_P0;
                state_next  = ST_MUL_P1;
            end
            ST_MUL_P1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_P1;
                state_next  = ST_MUL_DEN;
            end
            ST_MUL_DEN:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_DEN;
                state_next  = ST_COMB;
            end
            ST_COMB:
            begin
                cmd.comb   = 1'b1;
                state_next = stat.early ? ST_DONE : ST_GCD;
            end
            ST_GCD:
            begin
                if (stat.gcd_done)
                    state_next = ST_DIV_INIT;
                else
                    cmd.gcd_step = 1'b1;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                    state_next = ST_DONE;
                else
                    cmd.div_step = 1'b1;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.res_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    `RAU_ASSERT_NXT(a_accept_mul, s_tvalid && s_tready, state_reg == ST_MUL_P0, "accepted request did not start multiply")
    `RAU_ASSERT_IMP(a_load_free, cmd.res_load, !m_tvalid_reg || m_tready, "result overwritten before taken")
    `RAU_ASSERT_NXT(a_div_end, (state_reg == ST_DIV) && stat.div_done, state_reg == ST_DONE, "divide end not followed by done")

endmodule

// ----- design/rational_arith_unit.sv -----
// Rational arithmetic unit: takes one request (opcode and two rationals) at a
// time and returns one result, reduced by the GCD with the sign on the
// numerator. A request whose result needs no reduction (comparison, unknown
// opcode, undefined result or zero result) skips the GCD and divide steps;
// otherwise the binary GCD runs one step per cycle on 32-bit magnitudes and
// the pair of bit-serial dividers then makes 32 steps and a closing check.
// A new request is taken while the previous result still waits in the output
// register.
// ----------------------------------------------------------------------------
// rational_arith_unit
// Top level: stream ports around the controller and the datapath.
// ----------------------------------------------------------------------------
module rational_arith_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // opcode, a_num, a_den, b_num, b_den, zero pad
    input  logic [rau_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // res_num, res_den, truth, zero pad
    output logic [rau_pkg::M_TDATA_W-1:0]  m_tdata,
    // is_undefined
    output logic                           m_tuser
);
    import rau_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    rau_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .res_tdata (m_tdata),
        .res_undef (m_tuser)
    );

endmodule

// ----- tb/sv/rational_arith_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit_tb
// Drives requests of two rationals and an opcode through the stream slave,
// predicts each reduced result in the bench unless a directed row types it,
// and compares it on the master side. A directed table comes first, then
// random requests with random gaps on both sides and one long result stall.
// ----------------------------------------------------------------------------
module rational_arith_unit_tb;
    import rau_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [2:0]  opcode;
        logic [15:0] a_num;
        logic [15:0] a_den;
        logic [15:0] b_num;
        logic [15:0] b_den;
    } rat_req_t;

    typedef struct packed {
        logic [32:0] res_num;
        logic [30:0] res_den;
        logic        is_undefined;
        logic        truth;
    } rat_res_t;

    // directed row: request, typed result where it is obvious
    typedef struct {
        rat_req_t req;
        logic     has_typed;
        rat_res_t typed;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;

    rat_res_t result_q[$];
    int       mismatch_cnt;
    int       result_cnt;
    int       idle_cycles;
    bit       send_done;
    bit       long_stall;
    dir_row_t dir_rows[$];

    rational_arith_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Exact arithmetic in signed 64 bits; 16-bit operands never overflow it.
    function automatic rat_res_t predict_rational(rat_req_t r);
        rat_res_t        res;
        longint          an, ad, bn, bd, num, den, diff;
        longint unsigned nm, dm, g;
        bit              a_undef, b_undef;
        an = longint'($signed(r.a_num));
        ad = longint'($signed(r.a_den));
        bn = longint'($signed(r.b_num));
        bd = longint'($signed(r.b_den));
        a_undef = (ad == 0);
        b_undef = (bd == 0);
        res = '{default: '0};
        if (r.opcode > OP_GT)
            return res;
        if (r.opcode == OP_EQ || r.opcode == OP_GT)
        begin
            if (a_undef || b_undef)
                res.truth = (r.opcode == OP_EQ) ? (a_undef && b_undef)
                                                : (a_undef && !b_undef);
            else
            begin
                diff = an * bd - bn * ad;
                if (r.opcode == OP_EQ)
                    res.truth = (diff == 0);
                else
                    res.truth = (diff != 0) && ((diff < 0) == ((ad < 0) != (bd < 0)));
            end
            return res;
        end
        if (a_undef || b_undef)
        begin
            res.is_undefined = 1'b1;
            return res;
        end
        case (r.opcode)
            OP_ADD:  begin num = an * bd + bn * ad; den = ad * bd; end
            OP_SUB:  begin num = an * bd - bn * ad; den = ad * bd; end
            OP_MUL:  begin num = an * bn;           den = ad * bd; end
            default: begin num = an * bd;           den = ad * bn; end
        endcase
        if (den == 0)
        begin
            res.is_undefined = 1'b1;
            return res;
        end
        if (num == 0)
        begin
            res.res_den = 31'd1;
            return res;
        end
        nm = (num < 0) ? -num : num;
        dm = (den < 0) ? -den : den;
        g  = gcd64(nm, dm);
        nm = nm / g;
        dm = dm / g;
        res.res_num = ((num < 0) != (den < 0)) ? 33'(-nm) : 33'(nm);
        res.res_den = 31'(dm);
        return res;
    endfunction

    function automatic logic [15:0] rand_operand();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'(int'($urandom_range(0, 8)) - 4);
            4, 5:    return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic rat_req_t rand_request();
        rat_req_t r;
        r.opcode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                 : 3'($urandom_range(0, 5));
        r.a_num  = rand_operand();
        r.a_den  = rand_operand();
        r.b_num  = rand_operand();
        r.b_den  = rand_operand();
        return r;
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 200);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 4);
    endfunction

    task automatic add_row(logic [2:0] op, int an, int ad, int bn, int bd,
                           bit typed = 0, int rn = 0, int rd = 0,
                           bit und = 0, bit tr = 0);
        dir_row_t row;
        row.req       = '{op, 16'(an), 16'(ad), 16'(bn), 16'(bd)};
        row.has_typed = typed;
        row.typed     = '{33'(rn), 31'(rd), und, tr};
        dir_rows.push_back(row);
    endtask

    task automatic send_request(rat_req_t r, rat_res_t exp_res);
        s_tdata  <= {{(S_TDATA_W - 67){1'b0}}, r.b_den, r.b_num, r.a_den, r.a_num, r.opcode};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        result_q.push_back(exp_res);
        @(negedge clk);
    endtask

    task automatic send_with_gap(rat_req_t r, rat_res_t exp_res);
        int gap;
        gap = rand_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        send_request(r, exp_res);
    endtask

    initial
    begin
        rat_req_t r;
        rat_res_t pred;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        send_done = 1'b0;
        rst_n     = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        add_row(OP_ADD, 1, 2, 1, 3);
        add_row(OP_ADD, 1, 0, 1, 3, 1, 0, 0, 1, 0);
        add_row(OP_SUB, 1, 2, 1, 2, 1, 0, 1, 0, 0);
        add_row(OP_SUB, -32768, 1, 32767, 1);
        add_row(OP_MUL, -32768, -32768, -32768, -32768, 1, 1, 1, 0, 0);
        add_row(OP_MUL, 32767, 1, 32767, 1);
        add_row(OP_MUL, 0, -5, 7, 3, 1, 0, 1, 0, 0);
        add_row(OP_MUL, 3, -4, 2, 9);
        add_row(OP_DIV, 3, 4, 0, 5, 1, 0, 0, 1, 0);
        add_row(OP_DIV, 1, 32767, -32768, 1);
        add_row(OP_DIV, -6, 4, 3, -8);
        add_row(OP_EQ, 1, 2, 2, 4, 1, 0, 0, 0, 1);
        add_row(OP_EQ, 1, 0, 5, 0, 1, 0, 0, 0, 1);
        add_row(OP_EQ, 1, 0, 5, 1, 1, 0, 0, 0, 0);
        add_row(OP_GT, 1, 0, 5, 1, 1, 0, 0, 0, 1);
        add_row(OP_GT, 5, 1, 1, 0, 1, 0, 0, 0, 0);
        add_row(OP_GT, 1, 0, 1, 0, 1, 0, 0, 0, 0);
        add_row(OP_GT, 1, -2, 1, 3);
        add_row(OP_GT, -1, -2, 1, 3);
        add_row(OP_GT, 2, 4, 1, 2, 1, 0, 0, 0, 0);
        add_row(3'd6, 1, 1, 1, 1, 1, 0, 0, 0, 0);
        add_row(3'd7, -1, -1, -1, -1, 1, 0, 0, 0, 0);

        foreach (dir_rows[i])
            send_with_gap(dir_rows[i].req, dir_rows[i].has_typed ? dir_rows[i].typed
                                                               : predict_rational(dir_rows[i].req));
        for (int n = 0; n < 1000; n++)
        begin
            r    = rand_request();
            pred = predict_rational(r);
            send_with_gap(r, pred);
        end
        s_tvalid  <= 1'b0;
        send_done = 1'b1;
    end

    // Result side: random stalls, one long hold-off early in the random part.
    initial
    begin
        int gap;
        m_tready   = 1'b0;
        long_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_stall && result_cnt > 40)
            begin
                long_stall = 1'b1;
                m_tready <= 1'b0;
                repeat (1500) @(negedge clk);
            end
            gap = rand_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        rat_res_t got;
        rat_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            result_cnt++;
            got.res_num      = m_tdata[32:0];
            got.res_den      = m_tdata[63:33];
            got.truth        = m_tdata[64];
            got.is_undefined = m_tuser;
            if (result_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result num=%0d den=%0d", $signed(got.res_num),
                             got.res_den);
            end
            else
            begin
                want = result_q.pop_front();
                if (got != want)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp num=%0d den=%0d und=%0b t=%0b, got num=%0d den=%0d und=%0b t=%0b",
                                 $signed(want.res_num), want.res_den, want.is_undefined,
                                 want.truth, $signed(got.res_num), got.res_den,
                                 got.is_undefined, got.truth);
                end
            end
        end
    end

    // Watchdog: count cycles with no request or result moving.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        mismatch_cnt = 0;
        result_cnt   = 0;
        idle_cycles  = 0;
        fork
            begin
                wait (send_done && result_q.size() == 0);
                repeat (400) @(posedge clk);
            end
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
                mismatch_cnt++;
            end
        join_any
        if (mismatch_cnt == 0)
            $display("rational_arith_unit_tb: clean");
        else
            $display("rational_arith_unit_tb: errors");
        $finish;
    end

endmodule

// ----- rational_arith_unit.f -----
+incdir+design
design/rau_pkg.sv
design/rau_datapath.sv
design/rau_ctrl.sv
design/rational_arith_unit.sv
tb/sv/rational_arith_unit_tb.sv
